### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent check, disabled while the active-low reset is asserted.
`define ASSERT_IFF(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent check that also holds through reset.
`define ASSERT_NOW(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_IFF(label, clk, rstn, prop, msg)
`define ASSERT_NOW(label, clk, prop, msg)

`endif

`endif

### rtl/core/cmlmf_pkg.sv
// Types, constants and helpers of the charge map local maximum finder.
// No dependencies.
`default_nettype none

package cmlmf_pkg;

  localparam int LINE_MAX = 256;            // longest raster line
  localparam int COL_W    = $clog2(LINE_MAX);
  localparam int LEN_W    = 9;              // line_length register
  localparam int CHG_W    = 14;             // unsigned 10.4 charge
  localparam int LIN_W    = 16;             // line counter, saturating
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int S_DW     = 16;             // present, charge, pad
  localparam int S_UW     = 2;              // new_frame, drain
  localparam int M_DW     = 40;             // is_peak, charge, column, line, pad
  localparam int M_UW     = 1;              // cell_valid

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(170);
  localparam logic [CHG_W-1:0] THR_RESET = CHG_W'(48);
  localparam logic [LIN_W-1:0] LINE_SAT  = '1;

  typedef enum logic [0:0] {
    REG_LINE_LENGTH = 1'b0,
    REG_THRESHOLD   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             present;
    logic [CHG_W-1:0] charge;
  } cell_t;

  // one line-memory word: two lines above the input column
  typedef struct packed {
    cell_t above2;   // two lines up
    cell_t above;    // one line up
  } entry_t;

  function automatic logic [LIN_W-1:0] sat_inc(input logic [LIN_W-1:0] v);
    sat_inc = (v == LINE_SAT) ? v : v + LIN_W'(1);
  endfunction

endpackage

`default_nettype wire

### rtl/core/charge_map_local_maximum_finder_core.sv
// Top level of the charge map local maximum finder: 3x3 peak search.
// Depends on cmlmf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Scans one pad-time plane in raster order, one cell per input beat, and
// returns one verdict beat per input beat for the cell one line and one
// column behind it. A present cell whose charge reaches the threshold and is
// not below any present in-frame neighbor of its 3x3 window is a peak (ties
// give both). Sustained rate is one beat per clock while the output is not
// stalled. Each accepted input beat is registered in stage 1 together with its
// line-memory read; when stage 1 advances, the window compare and write-back
// result are registered in the output register. Both line stores share a
// single 256 x 30 bit memory with a registered read; a column's write-back is
// forwarded to the next read when consecutive beats hit the same column
// (line length 1, or a new frame restarting at column 0). Each memory word
// has a valid flop cleared by reset, so no clearing pass is needed and the
// block is ready right out of reset. new_frame restarts counters and the
// window but leaves the line memory as it is; drain beats flush the last
// line and are reported as not valid from the first drain position on.
// Configuration: APB, register 0 line_length at 0x0, register 1
// charge_threshold at 0x4; write only while the block is idle.
module charge_map_local_maximum_finder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input cells
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cmlmf_pkg::S_DW-1:0]      s_tdata,   // present, charge[14:1], zero pad
  input  logic [cmlmf_pkg::S_UW-1:0]      s_tuser,   // new_frame, drain
  // verdicts
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cmlmf_pkg::M_DW-1:0]      m_tdata,   // is_peak, peak_charge[14:1],
                                                     // column[22:15], line[38:23], pad
  output logic [cmlmf_pkg::M_UW-1:0]      m_tuser,   // cell_valid
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cmlmf_pkg::APB_AW-1:0]    paddr,
  input  logic [cmlmf_pkg::APB_DW-1:0]    pwdata,
  output logic [cmlmf_pkg::APB_DW-1:0]    prdata,
  output logic                            pready
);
  import cmlmf_pkg::*;

  // ---------------------------------------------------------------- config
  logic [LEN_W-1:0] len_q;
  logic [CHG_W-1:0] thr_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[2]))
        REG_LINE_LENGTH: len_q <= pwdata[LEN_W-1:0];
        REG_THRESHOLD:   thr_q <= pwdata[CHG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[2]))
      REG_LINE_LENGTH: prdata = APB_DW'(len_q);
      REG_THRESHOLD:   prdata = APB_DW'(thr_q);
      default:         prdata = '0;
    endcase
  end

  // effective line length: 0 acts as 1, clamp at memory depth
  logic [LEN_W-1:0] weff;
  logic [LEN_W-1:0] weff_m1;

  always_comb begin
    if (len_q == '0)                     weff = LEN_W'(1);
    else if (len_q > LEN_W'(LINE_MAX))   weff = LEN_W'(LINE_MAX);
    else                                 weff = len_q;
  end
  assign weff_m1 = weff - LEN_W'(1);

  // ---------------------------------------------------------------- stage 0
  // position counters and drain tracking; line-memory read issued here
  logic [COL_W-1:0] col_q, col_d;
  logic [LIN_W-1:0] line_q, line_d;
  logic             drn_q, drn_d;
  logic [LIN_W-1:0] dline_q, dline_d;
  logic [COL_W-1:0] dcol_q, dcol_d;

  logic             s_acc, s_nf, s_drain, s_pres;
  logic [CHG_W-1:0] s_chg;

  assign s_acc   = s_tvalid && s_tready;
  assign s_nf    = s_tuser[0];
  assign s_drain = s_tuser[1];
  assign s_pres  = s_tdata[0];
  assign s_chg   = s_tdata[CHG_W:1];

  logic [COL_W-1:0] col_s, c0;
  logic [LIN_W-1:0] line_s, l0;
  logic             drn_s, wrap_s, wrap_e;
  logic [LEN_W-1:0] col_inc;
  cell_t            cell0;
  logic             pos_ok0, real0, top0, left0, right0;
  logic [LIN_W-1:0] cl0;
  logic [COL_W-1:0] cc0;

  always_comb begin
    // new_frame acts before anything else
    col_s  = s_nf ? '0   : col_q;
    line_s = s_nf ? '0   : line_q;
    drn_s  = s_nf ? 1'b0 : drn_q;

    // catch a column left beyond a shortened line
    wrap_s = {1'b0, col_s} >= weff;
    c0     = wrap_s ? '0 : col_s;
    l0     = wrap_s ? sat_inc(line_s) : line_s;

    drn_d   = drn_s | s_drain;
    dline_d = (s_drain && !drn_s) ? l0 : dline_q;
    dcol_d  = (s_drain && !drn_s) ? c0 : dcol_q;

    cell0 = '0;
    if (!drn_d && s_pres) begin
      cell0.present = 1'b1;
      cell0.charge  = s_chg;
    end

    col_inc = {1'b0, c0} + LEN_W'(1);
    wrap_e  = col_inc >= weff;
    col_d   = wrap_e ? '0 : col_inc[COL_W-1:0];
    line_d  = wrap_e ? sat_inc(l0) : l0;

    // reported cell sits one line and one column back
    if (c0 != '0) begin
      pos_ok0 = l0 != '0;
      cl0     = l0 - LIN_W'(1);
      cc0     = c0 - COL_W'(1);
    end else begin
      pos_ok0 = l0 >= LIN_W'(2);
      cl0     = l0 - LIN_W'(2);
      cc0     = weff_m1[COL_W-1:0];
    end
    real0 = pos_ok0 &&
            (!drn_d || (cl0 < dline_d) || ((cl0 == dline_d) && (cc0 < dcol_d)));

    top0   = cl0 == '0;
    left0  = cc0 == '0;
    right0 = cc0 == weff_m1[COL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      line_q  <= '0;
      drn_q   <= 1'b0;
      dline_q <= '0;
      dcol_q  <= '0;
    end else if (s_acc) begin
      col_q   <= col_d;
      line_q  <= line_d;
      drn_q   <= drn_d;
      dline_q <= dline_d;
      dcol_q  <= dcol_d;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic             s1_valid_q;
  logic             s1_nf_q;
  cell_t            s1_cell_q;
  logic [COL_W-1:0] s1_addr_q;
  logic             s1_real_q, s1_top_q, s1_left_q, s1_right_q;
  logic [LIN_W-1:0] s1_cl_q;
  logic [COL_W-1:0] s1_cc_q;
  logic             s1_fwd_q;
  entry_t           s1_fwd_data_q;
  entry_t           s1_rd_q;
  logic             s1_rd_vld_q;
  logic             s1_adv;

  assign s1_adv   = s1_valid_q && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid_q || s1_adv;

  // line memory: one word per column, valid flop per word
  entry_t              line_mem_q [LINE_MAX];
  logic [LINE_MAX-1:0] mem_vld_q;
  entry_t              ent, wr_data;

  always_comb begin
    if (s1_fwd_q)         ent = s1_fwd_data_q;
    else if (s1_rd_vld_q) ent = s1_rd_q;
    else                  ent = '0;
    wr_data.above2 = ent.above;
    wr_data.above  = s1_cell_q;
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_rd_q <= line_mem_q[c0];
    end
    if (s1_adv) begin
      line_mem_q[s1_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
    end else if (s1_adv) begin
      mem_vld_q[s1_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
      // same column written back this cycle: memory read is stale
      s1_fwd_q   <= s1_adv && (s1_addr_q == c0);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_nf_q       <= s_nf;
      s1_cell_q     <= cell0;
      s1_addr_q     <= c0;
      s1_real_q     <= real0;
      s1_top_q      <= top0;
      s1_left_q     <= left0;
      s1_right_q    <= right0;
      s1_cl_q       <= cl0;
      s1_cc_q       <= cc0;
      s1_fwd_data_q <= wr_data;
      s1_rd_vld_q   <= mem_vld_q[c0];
    end
  end

  // window: only the two newest columns are kept
  cell_t win1_q [3];
  cell_t win2_q [3];
  cell_t src1 [3];
  cell_t src2 [3];
  cell_t ncol [3];
  cell_t ctr;
  logic  peak;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      src1[r] = s1_nf_q ? '0 : win1_q[r];
      src2[r] = s1_nf_q ? '0 : win2_q[r];
    end
    ncol[0] = ent.above2;
    ncol[1] = ent.above;
    ncol[2] = s1_cell_q;
    ctr     = src2[1];

    peak = s1_real_q && ctr.present && (ctr.charge >= thr_q);
    for (int r = 0; r < 3; r++) begin
      if (!(r == 0 && s1_top_q)) begin
        if (!s1_left_q && src1[r].present && (src1[r].charge > ctr.charge))
          peak = 1'b0;
        if (r != 1 && src2[r].present && (src2[r].charge > ctr.charge))
          peak = 1'b0;
        if (!s1_right_q && ncol[r].present && (ncol[r].charge > ctr.charge))
          peak = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win1_q[r] <= '0;
        win2_q[r] <= '0;
      end
    end else if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win1_q[r] <= src2[r];
        win2_q[r] <= ncol[r];
      end
    end
  end

  // ---------------------------------------------------------------- output
  logic             m_tvalid_q;
  logic [M_DW-1:0]  m_tdata_q;
  logic [M_UW-1:0]  m_tuser_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_tuser_q <= s1_real_q;
      m_tdata_q <= '0;
      if (s1_real_q) begin
        m_tdata_q[0]       <= peak;
        m_tdata_q[CHG_W:1] <= ctr.present ? ctr.charge : '0;
        m_tdata_q[CHG_W+COL_W:CHG_W+1]                   <= s1_cc_q;
        m_tdata_q[CHG_W+COL_W+LIN_W:CHG_W+COL_W+1]       <= s1_cl_q;
      end
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;
  assign m_tuser  = m_tuser_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_NOW(a_invalid_zero, clk_i, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0), "invalid beat carries data")
  `ASSERT_IFF(a_fwd_needs_s1, clk_i, rst_ni, s1_fwd_q |-> s1_valid_q, "forward flag without stage-1 beat")
  `ASSERT_IFF(a_no_overrun, clk_i, rst_ni, (s1_valid_q && m_tvalid && !m_tready) |-> !s_tready, "accept while pipeline is full")
  `ASSERT_IFF(a_drain_sticky, clk_i, rst_ni, (drn_q && !(s_acc && s_nf)) |=> drn_q, "drain dropped without new frame")

endmodule

`default_nettype wire

### tb/charge_map_peak_checker.sv
// Scoreboard for the charge map local maximum finder: predicts one verdict per
// accepted cell beat and compares it with the verdict stream. Uses cmlmf_pkg.
`timescale 1ns / 1ps

module charge_map_peak_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [cmlmf_pkg::S_DW-1:0]   s_tdata,   // present, charge[14:1], zero pad
  input  logic [cmlmf_pkg::S_UW-1:0]   s_tuser,   // new_frame, drain
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [cmlmf_pkg::M_DW-1:0]   m_tdata,   // is_peak, charge, column, line, pad
  input  logic [cmlmf_pkg::M_UW-1:0]   m_tuser,   // cell_valid
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cmlmf_pkg::APB_AW-1:0] paddr,
  input  logic [cmlmf_pkg::APB_DW-1:0] pwdata,
  input  logic                         pready,
  output int                           fail_count_o,
  output int                           pending_o
);
  import cmlmf_pkg::*;

  typedef struct packed {
    logic             vld;
    logic             peak;
    logic [CHG_W-1:0] chg;
    logic [7:0]       col;
    logic [LIN_W-1:0] lin;
  } verdict_t;

  verdict_t    verdict_q[$];
  int          n_bad = 0;

  logic [LEN_W-1:0] len_cfg;
  logic [CHG_W-1:0] thr_cfg;
  cell_t            row1_mem[LINE_MAX];   // one line above
  cell_t            row2_mem[LINE_MAX];   // two lines above
  cell_t            win[3][3];
  int unsigned      col_cnt, lin_cnt, drain_lin, drain_col;
  bit               draining;

  function automatic void bump_line();
    col_cnt = 0;
    if (lin_cnt < 65535) lin_cnt++;
  endfunction

  function automatic verdict_t judge_cell(logic nf, logic dr, logic pr,
                                          logic [CHG_W-1:0] ch);
    int unsigned w, c, l, cl, cc;
    cell_t       cur, up1, up2, ctr, nb;
    bit          pos_ok, real_cell, peak;
    verdict_t    v;
    w = (len_cfg == 0) ? 1 : ((len_cfg > LINE_MAX) ? LINE_MAX : len_cfg);
    if (nf) begin
      col_cnt  = 0;
      lin_cnt  = 0;
      draining = 0;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) win[r][k] = '0;
    end
    if (col_cnt >= w) bump_line();
    c = col_cnt;
    l = lin_cnt;
    if (dr && !draining) begin
      draining  = 1;
      drain_lin = l;
      drain_col = c;
    end
    cur = (!draining && pr) ? cell_t'{1'b1, ch} : '0;

    up1 = row1_mem[c];
    up2 = row2_mem[c];
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = cur;
    row2_mem[c] = up1;
    row1_mem[c] = cur;

    // centre sits one line and one column back, wrapping to the prior line
    if (c >= 1) begin
      pos_ok = (l >= 1);
      cl = l - 1;
      cc = c - 1;
    end else begin
      pos_ok = (l >= 2);
      cl = l - 2;
      cc = w - 1;
    end
    real_cell = pos_ok && (!draining || cl < drain_lin ||
                           (cl == drain_lin && cc < drain_col));
    v = '0;
    if (real_cell) begin
      ctr  = win[1][1];
      peak = ctr.present && (ctr.charge >= thr_cfg);
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          nb = win[r][k];
          if ((r == 0 && cl == 0) || (r == 1 && k == 1) ||
              (k == 0 && cc == 0) || (k == 2 && cc == w - 1)) continue;
          if (nb.present && nb.charge > ctr.charge) peak = 0;
        end
      end
      v.vld  = 1'b1;
      v.peak = peak;
      v.chg  = ctr.present ? ctr.charge : '0;
      v.col  = cc[7:0];
      v.lin  = cl[LIN_W-1:0];
    end
    col_cnt = c + 1;
    if (col_cnt >= w) bump_line();
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t want, got;
    if (!rst_ni) begin
      len_cfg  = LEN_RESET;
      thr_cfg  = THR_RESET;
      col_cnt  = 0;
      lin_cnt  = 0;
      draining = 0;
      drain_lin = 0;
      drain_col = 0;
      for (int i = 0; i < LINE_MAX; i++) begin
        row1_mem[i] = '0;
        row2_mem[i] = '0;
      end
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) win[r][k] = '0;
      verdict_q.delete();
      pending_o    <= 0;
      fail_count_o <= n_bad;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[2]))
          REG_LINE_LENGTH: len_cfg = pwdata[LEN_W-1:0];
          REG_THRESHOLD:   thr_cfg = pwdata[CHG_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        verdict_q = {verdict_q, judge_cell(s_tuser[0], s_tuser[1], s_tdata[0],
                                           s_tdata[14:1])};
      if (m_tvalid && m_tready) begin
        got = '{m_tuser[0], m_tdata[0], m_tdata[14:1], m_tdata[22:15], m_tdata[38:23]};
        if (verdict_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("checker: verdict beat with none pending");
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("checker: mismatch exp vld=%0d peak=%0d chg=%0d col=%0d line=%0d",
                       want.vld, want.peak, want.chg, want.col, want.lin,
                       " got vld=%0d peak=%0d chg=%0d col=%0d line=%0d",
                       got.vld, got.peak, got.chg, got.col, got.lin);
          end
        end
      end
      pending_o    <= verdict_q.size();
      fail_count_o <= n_bad;
    end
  end

endmodule

### tb/tb_charge_map_local_maximum_finder_core.sv
// Top of the charge map local maximum finder testbench: clock, reset, APB
// setup, cell stimulus and verdict. Uses cmlmf_pkg and charge_map_peak_checker.
`timescale 1ns / 1ps

module tb_charge_map_local_maximum_finder_core;
  import cmlmf_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DW-1:0]      s_tdata = '0;    // present, charge[14:1], zero pad
  logic [S_UW-1:0]      s_tuser = '0;    // new_frame, drain
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DW-1:0]      m_tdata;         // is_peak, charge, column, line, pad
  logic [M_UW-1:0]      m_tuser;         // cell_valid
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [APB_AW-1:0]    paddr   = '0;
  logic [APB_DW-1:0]    pwdata  = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  int                   fail_cnt;
  int                   pending_cnt;
  int unsigned          cycle_cnt = 0;

  // idle percentages, switched per phase
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;

  // copy of the settings the cell generator aims at
  logic [LEN_W-1:0]     len_cur = LEN_RESET;
  logic [CHG_W-1:0]     thr_cur = THR_RESET;

  // frame generator state: real cells left, then flush beats left
  int unsigned          frame_left = 0;
  int unsigned          flush_left = 0;

  charge_map_local_maximum_finder_core dut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  charge_map_peak_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_cnt), .pending_o(pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output side backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // 0: sender idles 10%, receiver 61%; 1: the reverse; 2: no idling
  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 10; recv_stall_pct = 61; end
      1: begin send_idle_pct = 61; recv_stall_pct = 10; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // two-phase APB write; the register takes it on the access edge
  task automatic apb_write(input cfg_reg_e idx, input logic [APB_DW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one cell beat; valid stays up between back-to-back beats, and each idle
  // cycle is drawn on its own
  task automatic send_cell(input logic nf, input logic dr, input logic pr,
                           input logic [CHG_W-1:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, ch, pr};
    s_tuser  <= {dr, nf};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // stop sending, let every pending verdict come out, then reprogram
  task automatic quiesce_and_configure(input logic [LEN_W-1:0] len,
                                       input logic [CHG_W-1:0] thr);
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    len_cur = len;
    thr_cur = thr;
    apb_write(REG_LINE_LENGTH, APB_DW'(len));
    apb_write(REG_THRESHOLD, APB_DW'(thr));
  endtask

  // charges cluster around the threshold and at small values so ties and
  // threshold edges come up often; the rest spans the whole range or sits at its ends
  function automatic logic [CHG_W-1:0] pick_charge();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 16383);
      1: v = $urandom_range(0, 7);
      2: v = int'(thr_cur) + int'($urandom_range(0, 4)) - 2;
      default: v = $urandom_range(0, 1) ? 16383 - int'($urandom_range(0, 2)) : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return CHG_W'(v);
  endfunction

  // mostly whole frames followed by a full flush line; some frames are cut
  // short, and a little noise drops new_frame and drain into the middle
  task automatic next_cell(output logic nf, output logic dr, output logic pr,
                           output logic [CHG_W-1:0] ch);
    int unsigned w;
    int unsigned r;
    bit          first;
    w = (len_cur == 0) ? 1 : ((len_cur > LINE_MAX) ? LINE_MAX : len_cur);
    first = 0;
    if (frame_left == 0 && flush_left == 0) begin
      first = 1;
      if ($urandom_range(0, 99) < 85) begin
        frame_left = w * $urandom_range(1, 3);
        flush_left = w + 2;
      end else begin
        frame_left = $urandom_range(1, 3 * w);
        flush_left = $urandom_range(0, 3);
      end
    end
    pr = ($urandom_range(0, 99) < 60);
    ch = pick_charge();
    nf = first;
    dr = 1'b0;
    if (frame_left > 0) begin
      frame_left--;
      r = $urandom_range(0, 99);
      if (first && r < 3) dr = 1'b1;        // new frame and drain together
      else if (!first && r < 2) nf = 1'b1;  // stray frame restart
      else if (!first && r < 3) dr = 1'b1;  // early drain
    end else begin
      flush_left--;
      dr = 1'b1;
    end
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input logic [CHG_W-1:0] thr,
                           input int n_items, input int mode);
    logic             nf, dr, pr;
    logic [CHG_W-1:0] ch;
    quiesce_and_configure(len, thr);
    set_idle(mode);
    for (int i = 0; i < n_items; i++) begin
      next_cell(nf, dr, pr, ch);
      send_cell(nf, dr, pr, ch);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: three-wide frame with extreme charges, ties, threshold edge,
    // absent cells, drain with present set, new frame with drain
    quiesce_and_configure(LEN_W'(3), CHG_W'(48));
    set_idle(0);
    send_cell(1'b1, 1'b0, 1'b1, 14'h3FFF);
    send_cell(1'b0, 1'b0, 1'b1, 14'h3FFF);
    send_cell(1'b0, 1'b0, 1'b0, 14'h2AAA);
    send_cell(1'b0, 1'b0, 1'b1, 14'd48);
    send_cell(1'b0, 1'b0, 1'b1, 14'd47);
    send_cell(1'b0, 1'b0, 1'b1, 14'h1555);
    send_cell(1'b0, 1'b0, 1'b1, 14'd0);
    send_cell(1'b0, 1'b0, 1'b0, 14'd0);
    send_cell(1'b0, 1'b0, 1'b1, 14'd100);
    send_cell(1'b0, 1'b0, 1'b1, 14'd100);
    send_cell(1'b0, 1'b0, 1'b1, 14'd99);
    send_cell(1'b0, 1'b0, 1'b1, 14'd48);
    send_cell(1'b0, 1'b1, 1'b1, 14'h3FFF);
    send_cell(1'b0, 1'b0, 1'b1, 14'd500);
    send_cell(1'b0, 1'b0, 1'b0, 14'd0);
    send_cell(1'b0, 1'b0, 1'b1, 14'd7);
    send_cell(1'b1, 1'b1, 1'b1, 14'd900);
    send_cell(1'b0, 1'b1, 1'b0, 14'd0);
    send_cell(1'b0, 1'b0, 1'b1, 14'd20);
    send_cell(1'b1, 1'b0, 1'b1, 14'd60);
    send_cell(1'b0, 1'b0, 1'b1, 14'd60);
    send_cell(1'b0, 1'b0, 1'b1, 14'd61);
    send_cell(1'b0, 1'b1, 1'b0, 14'd0);
    send_cell(1'b0, 1'b1, 1'b0, 14'd0);
    send_cell(1'b0, 1'b1, 1'b0, 14'd0);

    // random phases; phase boundaries may fall mid-frame, so a lowered line
    // length also hits a column counter past the new end
    run_phase(LEN_W'(4),   CHG_W'(48),                   200, 0);
    run_phase(LEN_W'(1),   CHG_W'(20),                   150, 0);
    run_phase(LEN_W'(511), CHG_W'($urandom_range(0, 64)), 500, 0);
    run_phase(LEN_W'(7),   CHG_W'(0),                    250, 1);
    run_phase(LEN_W'(5),   CHG_W'(16383),                200, 1);
    run_phase(LEN_W'(2),   CHG_W'($urandom_range(0, 16383)), 200, 1);
    run_phase(LEN_W'(33),  CHG_W'($urandom_range(0, 200)), 250, 2);
    run_phase(LEN_W'(3),   CHG_W'(4096),                 250, 2);

    // zero length counts as one: a short frame of one-cell lines
    quiesce_and_configure(LEN_W'(0), CHG_W'(0));
    set_idle(2);
    send_cell(1'b1, 1'b0, 1'b1, pick_charge());
    for (int i = 0; i < 60; i++)
      send_cell(1'b0, 1'b0, 1'($urandom_range(0, 1)), pick_charge());

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
